// ----- hdl/running_sum_mean_stddev_macros.svh -----
// assertion macros shared by the running_sum_mean_stddev block
// no dependencies; taken in by the files that hold assertions
`ifndef RUNNING_SUM_MEAN_STDDEV_MACROS_SVH
`define RUNNING_SUM_MEAN_STDDEV_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RSMS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define RSMS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rsms_pkg.sv -----
// shared types, widths and helpers of the running_sum_mean_stddev block
// no dependencies; used by every module of the block
package rsms_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int COUNT_BITS   = 24;
    localparam int SUM_BITS     = 40;
    localparam int SQ_BITS      = 56;
    localparam int MEAN_BITS    = 24;
    localparam int DEV_BITS     = 24;
    localparam int MEAN_FRAC    = 8;
    localparam int DEV_FRAC     = 16;
    localparam int PROD_BITS    = 80;
    localparam int MPLIER_BITS  = 40;
    localparam int DIV_NUM_BITS = 96;
    localparam int DIV_DEN_BITS = 48;
    localparam int ROOT_BITS    = 48;
    localparam int STEP_BITS    = 7;
    localparam int MUL_STEPS    = 40;
    localparam int DIV_STEPS    = 96;
    localparam int ROOT_STEPS   = 24;

    localparam logic [MEAN_BITS-1:0] MEAN_POS_LIMIT = {1'b0, {(MEAN_BITS-1){1'b1}}};
    localparam logic [MEAN_BITS-1:0] MEAN_NEG_LIMIT = {1'b1, {(MEAN_BITS-1){1'b0}}};
    localparam logic [ROOT_BITS-1:0] ROOT_TOP       = {2'b01, {(ROOT_BITS-2){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_null;
        logic                          end_of_group;
    } item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]       sample_count;
        logic signed [SUM_BITS-1:0]  total;
        logic signed [MEAN_BITS-1:0] mean_q8;
        logic                        mean_valid;
        logic [DEV_BITS-1:0]         deviation_q8;
        logic                        deviation_valid;
        logic                        overflowed;
    } result_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_RUN,
        ST_STORE,
        ST_FINISH
    } state_t;

    // finalize phases, run in this order
    typedef enum logic [2:0] {
        PH_NSQ,
        PH_SUMSQ,
        PH_DEN,
        PH_MEAN,
        PH_DEV,
        PH_ROOT
    } phase_t;

    typedef struct packed {
        logic   acc;
        logic   load;
        logic   step;
        logic   store;
        logic   finish;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic [STEP_BITS-1:0] phase_steps(input phase_t ph);
        logic [STEP_BITS-1:0] n;
        case (ph)
            PH_NSQ, PH_SUMSQ, PH_DEN: n = STEP_BITS'(MUL_STEPS);
            PH_MEAN, PH_DEV:          n = STEP_BITS'(DIV_STEPS);
            PH_ROOT:                  n = STEP_BITS'(ROOT_STEPS);
            default:                  n = STEP_BITS'(MUL_STEPS);
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/rsms_div.sv -----
// restoring divider, one quotient bit per step
// depends on rsms_pkg for widths
module rsms_div (
    input  logic                               clk,
    input  logic                               load,
    input  logic                               step,
    input  logic [rsms_pkg::DIV_NUM_BITS-1:0]  num,
    input  logic [rsms_pkg::DIV_DEN_BITS-1:0]  den,
    output logic [rsms_pkg::DIV_NUM_BITS-1:0]  quot,
    output logic [rsms_pkg::DIV_DEN_BITS-1:0]  rem
);

    logic [rsms_pkg::DIV_NUM_BITS-1:0] num_reg, num_next;
    logic [rsms_pkg::DIV_DEN_BITS-1:0] rem_reg, rem_next;
    logic [rsms_pkg::DIV_DEN_BITS-1:0] den_reg;
    logic [rsms_pkg::DIV_DEN_BITS:0]   rem_sh;
    logic [rsms_pkg::DIV_DEN_BITS:0]   rem_sub;
    logic                              ge;

    // numerator shifts out at the top while quotient bits shift in at the bottom
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[rsms_pkg::DIV_NUM_BITS-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        rem_next = ge ? rem_sub[rsms_pkg::DIV_DEN_BITS-1:0]
                      : rem_sh[rsms_pkg::DIV_DEN_BITS-1:0];
        num_next = {num_reg[rsms_pkg::DIV_NUM_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/rsms_dp.sv -----
// datapath: accumulators, shift-add multiplier, divider, square root, result register
// depends on rsms_pkg and rsms_div
module rsms_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  rsms_pkg::cmd_t    cmd,
    input  rsms_pkg::item_t   item,
    output rsms_pkg::status_t status,
    output rsms_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);

    localparam int CB = rsms_pkg::COUNT_BITS;
    localparam int SB = rsms_pkg::SUM_BITS;
    localparam int QB = rsms_pkg::SQ_BITS;
    localparam int PB = rsms_pkg::PROD_BITS;
    localparam int MB = rsms_pkg::MPLIER_BITS;
    localparam int NB = rsms_pkg::DIV_NUM_BITS;
    localparam int DB = rsms_pkg::DIV_DEN_BITS;
    localparam int RB = rsms_pkg::ROOT_BITS;
    localparam int AB = rsms_pkg::MEAN_BITS;
    localparam int VB = rsms_pkg::DEV_BITS;
    localparam int XB = rsms_pkg::SAMPLE_BITS;

    // accumulators
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic [QB-1:0] sq_reg, sq_next;
    logic          ovf_reg, ovf_next;

    logic signed [2*XB-1:0] square_s;
    logic [SB-1:0]          sample_ext;
    logic [SB-1:0]          abs_sum;
    logic [CB-1:0]          cnt_m1;
    logic                   cnt_ge1;
    logic                   cnt_ge2;

    // multiplier
    logic [PB-1:0] mcand_reg, mcand_next;
    logic [MB-1:0] mplier_reg, mplier_next;
    logic [PB-1:0] prod_reg, prod_next;

    // finalize values
    logic [PB-1:0] a_reg;
    logic [PB-1:0] b_reg;
    logic [DB-1:0] d_reg;
    logic          a_gt_b_reg;
    logic [PB-1:0] diff;
    logic [AB-1:0] mean_reg, mean_val;
    logic          big_reg;
    logic [VB-1:0] dev_val;

    // divider hookup
    logic          is_div;
    logic [NB-1:0] div_num;
    logic [DB-1:0] div_den;
    logic [NB-1:0] div_quot;
    logic [DB-1:0] div_rem;
    logic [DB:0]   mag;

    // square root
    logic [RB-1:0] x_reg, x_next;
    logic [RB-1:0] res_reg, res_next;
    logic [RB-1:0] bit_reg;
    logic [RB:0]   trial;

    // output register
    rsms_pkg::result_t result_reg;
    logic              result_valid_reg, result_valid_next;

    assign square_s   = item.sample * item.sample;
    assign sample_ext = {{(SB-XB){item.sample[XB-1]}}, item.sample};
    assign abs_sum    = sum_reg[SB-1] ? (~sum_reg + SB'(1)) : sum_reg;
    assign cnt_m1     = cnt_reg - CB'(1);
    assign cnt_ge1    = cnt_reg != '0;
    assign cnt_ge2    = cnt_reg > CB'(1);
    assign diff       = a_reg - b_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        ovf_next = ovf_reg;
        if (cmd.finish)
        begin
            cnt_next = '0;
            sum_next = '0;
            sq_next  = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.acc && !item.is_null)
        begin
            // saturated count: the sample is dropped and flagged
            if (&cnt_reg)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CB'(1);
                sum_next = sum_reg + sample_ext;
                sq_next  = sq_reg + {{(QB-2*XB){1'b0}}, square_s};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            sum_reg          <= '0;
            sq_reg           <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg          <= cnt_next;
            sum_reg          <= sum_next;
            sq_reg           <= sq_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // shift-add multiplier, one multiplier bit per step
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (cmd.load)
        begin
            prod_next = '0;
            case (cmd.phase)
                rsms_pkg::PH_NSQ:
                begin
                    mcand_next  = {{(PB-QB){1'b0}}, sq_reg};
                    mplier_next = {{(MB-CB){1'b0}}, cnt_reg};
                end
                rsms_pkg::PH_SUMSQ:
                begin
                    mcand_next  = {{(PB-SB){1'b0}}, abs_sum};
                    mplier_next = abs_sum;
                end
                rsms_pkg::PH_DEN:
                begin
                    mcand_next  = {{(PB-CB){1'b0}}, cnt_reg};
                    mplier_next = {{(MB-CB){1'b0}}, cnt_m1};
                end
                default:
                begin
                    mcand_next  = mcand_reg;
                    mplier_next = mplier_reg;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (mplier_reg[0])
            begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PB-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MB-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign is_div = (cmd.phase == rsms_pkg::PH_MEAN) || (cmd.phase == rsms_pkg::PH_DEV);

    always_comb
    begin
        if (cmd.phase == rsms_pkg::PH_MEAN)
        begin
            div_num = {{(NB-SB-rsms_pkg::MEAN_FRAC){1'b0}}, abs_sum,
                       {rsms_pkg::MEAN_FRAC{1'b0}}};
            div_den = {{(DB-CB){1'b0}}, cnt_reg};
        end
        else
        begin
            div_num = {diff, {rsms_pkg::DEV_FRAC{1'b0}}};
            div_den = d_reg;
        end
    end

    rsms_div u_div (
        .clk  (clk),
        .load (cmd.load && is_div),
        .step (cmd.step && is_div),
        .num  (div_num),
        .den  (div_den),
        .quot (div_quot),
        .rem  (div_rem)
    );

    // floored mean: a negative sum rounds its magnitude up
    always_comb
    begin
        mag      = {1'b0, div_quot[DB-1:0]} + {{DB{1'b0}}, |div_rem};
        mean_val = '0;
        if (cnt_ge1)
        begin
            if (!sum_reg[SB-1])
            begin
                mean_val = (div_quot[DB-1:0] > {{(DB-AB){1'b0}}, rsms_pkg::MEAN_POS_LIMIT})
                           ? rsms_pkg::MEAN_POS_LIMIT : div_quot[AB-1:0];
            end
            else
            begin
                mean_val = (mag > {{(DB+1-AB){1'b0}}, rsms_pkg::MEAN_NEG_LIMIT})
                           ? rsms_pkg::MEAN_NEG_LIMIT : (~mag[AB-1:0]) + AB'(1);
            end
        end
    end

    // digit-by-digit square root, one result bit per step
    always_comb
    begin
        trial    = {1'b0, res_reg} + {1'b0, bit_reg};
        x_next   = x_reg;
        res_next = {1'b0, res_reg[RB-1:1]};
        if ({1'b0, x_reg} >= trial)
        begin
            x_next   = x_reg - trial[RB-1:0];
            res_next = {1'b0, res_reg[RB-1:1]} + bit_reg;
        end
    end

    always_comb
    begin
        dev_val = '0;
        if (cnt_ge2 && a_gt_b_reg)
        begin
            dev_val = big_reg ? '1 : res_reg[VB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.phase)
                rsms_pkg::PH_NSQ:   a_reg <= prod_reg;
                rsms_pkg::PH_SUMSQ: b_reg <= prod_reg;
                rsms_pkg::PH_DEN:   d_reg <= prod_reg[DB-1:0];
                rsms_pkg::PH_MEAN:  mean_reg <= mean_val;
                rsms_pkg::PH_DEV:
                begin
                    x_reg   <= div_quot[RB-1:0];
                    big_reg <= |div_quot[NB-1:RB];
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load && (cmd.phase == rsms_pkg::PH_DEV))
        begin
            a_gt_b_reg <= a_reg > b_reg;
        end
        if (cmd.load && (cmd.phase == rsms_pkg::PH_ROOT))
        begin
            res_reg <= '0;
            bit_reg <= rsms_pkg::ROOT_TOP;
        end
        else if (cmd.step && (cmd.phase == rsms_pkg::PH_ROOT))
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
            bit_reg <= {2'b00, bit_reg[RB-1:2]};
        end
        if (cmd.finish)
        begin
            result_reg.sample_count    <= cnt_reg;
            result_reg.total           <= sum_reg;
            result_reg.mean_q8         <= mean_reg;
            result_reg.mean_valid      <= cnt_ge1;
            result_reg.deviation_q8    <= dev_val;
            result_reg.deviation_valid <= cnt_ge2;
            result_reg.overflowed      <= ovf_reg;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.finish)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    assign status.out_busy = result_valid_reg;
    assign result          = result_reg;
    assign result_valid    = result_valid_reg;

endmodule

// ----- hdl/rsms_ctrl.sv -----
// controller: accumulate state and the finalize sequencer
// depends on rsms_pkg for state, phase and command types
module rsms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              end_of_group,
    output logic              item_ready,
    output rsms_pkg::cmd_t    cmd,
    input  rsms_pkg::status_t status
);

    rsms_pkg::state_t state_reg, state_next;
    rsms_pkg::phase_t phase_reg, phase_next;
    logic [rsms_pkg::STEP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsms_pkg::ST_ACCUM;
            phase_reg <= rsms_pkg::PH_NSQ;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        item_ready = 1'b0;
        cmd        = '{acc: 1'b0, load: 1'b0, step: 1'b0, store: 1'b0,
                       finish: 1'b0, phase: phase_reg};
        case (state_reg)
            rsms_pkg::ST_ACCUM:
            begin
                item_ready = 1'b1;
                cmd.acc    = item_valid;
                if (item_valid && end_of_group)
                begin
                    state_next = rsms_pkg::ST_LOAD;
                    phase_next = rsms_pkg::PH_NSQ;
                end
            end
            rsms_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = rsms_pkg::ST_RUN;
            end
            rsms_pkg::ST_RUN:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + rsms_pkg::STEP_BITS'(1);
                if (step_reg == rsms_pkg::phase_steps(phase_reg) - rsms_pkg::STEP_BITS'(1))
                begin
                    state_next = rsms_pkg::ST_STORE;
                end
            end
            rsms_pkg::ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = rsms_pkg::ST_LOAD;
                case (phase_reg)
                    rsms_pkg::PH_NSQ:   phase_next = rsms_pkg::PH_SUMSQ;
                    rsms_pkg::PH_SUMSQ: phase_next = rsms_pkg::PH_DEN;
                    rsms_pkg::PH_DEN:   phase_next = rsms_pkg::PH_MEAN;
                    rsms_pkg::PH_MEAN:  phase_next = rsms_pkg::PH_DEV;
                    rsms_pkg::PH_DEV:   phase_next = rsms_pkg::PH_ROOT;
                    default:            state_next = rsms_pkg::ST_FINISH;
                endcase
            end
            rsms_pkg::ST_FINISH:
            begin
                // wait for the result register to drain
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = rsms_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = rsms_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

// ----- hdl/running_sum_mean_stddev.sv -----
// top level of the group statistics block: count, sum, mean and sample deviation
// depends on rsms_pkg, rsms_ctrl, rsms_dp and the assertion macro header
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+---------------------------
//  item     | item_valid / item_ready     | item   (rsms_pkg::item_t)
//  result   | result_valid / result_ready | result (rsms_pkg::result_t)
//
// one word per cycle while accumulating; an end_of_group word drops item_ready
// through finalize: three 40-step shift-add multiplies, two 96-step divides
// and a 24-step square root, each with a load and a store state, plus one finish
// finish waits while the previous result is still held in the result register
// reset clears the accumulators and the result valid; no clearing pass
`include "running_sum_mean_stddev_macros.svh"

module running_sum_mean_stddev (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  rsms_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output rsms_pkg::result_t result
);

    rsms_pkg::cmd_t    cmd;
    rsms_pkg::status_t status;

    rsms_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .end_of_group (item.end_of_group),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .status       (status)
    );

    rsms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    `RSMS_ASSERT_NEXT(a_eog_starts_finalize, clk, rst_n, item_valid && item_ready && item.end_of_group, !item_ready, "end of group did not stop intake")
    `RSMS_ASSERT_NOW(a_result_from_finalize, clk, rst_n, $rose(result_valid), !$past(item_ready), "result appeared outside finalize")
    `RSMS_ASSERT_NOW(a_dev_needs_two, clk, rst_n, result_valid && result.deviation_valid, result.mean_valid && (result.sample_count > rsms_pkg::COUNT_BITS'(1)), "deviation valid with fewer than two samples")
    `RSMS_ASSERT_NOW(a_empty_group, clk, rst_n, result_valid && !result.mean_valid, (result.sample_count == '0) && (result.mean_q8 == '0) && !result.deviation_valid, "empty group result not cleared")

endmodule
